FILE: rtl/biq_pkg.sv
// Shared types, constants and the microcode program of the biquad filter.
package biq_pkg;

	// Data widths
	localparam int SMP_W   = 16;  // audio sample
	localparam int COEF_W  = 16;  // Q2.14 coefficient
	localparam int DLY_W   = 24;  // delay value
	localparam int FRAC_W  = 14;  // fraction bits of a coefficient
	localparam int PROD_W  = COEF_W + DLY_W;
	localparam int TERM_W  = PROD_W - FRAC_W;
	localparam int ACC_W   = TERM_W + 2;
	localparam int NUM_COEF = 5;
	localparam int CIDX_W  = 3;

	// Register indexes of the configuration port
	localparam logic [CIDX_W-1:0] REG_ZERO_COEF_0 = 3'd0;
	localparam logic [CIDX_W-1:0] REG_ZERO_COEF_1 = 3'd1;
	localparam logic [CIDX_W-1:0] REG_ZERO_COEF_2 = 3'd2;
	localparam logic [CIDX_W-1:0] REG_POLE_COEF_1 = 3'd3;
	localparam logic [CIDX_W-1:0] REG_POLE_COEF_2 = 3'd4;

	// Coefficient select codes (same as the register indexes)
	localparam logic [CIDX_W-1:0] SEL_Z0 = REG_ZERO_COEF_0;
	localparam logic [CIDX_W-1:0] SEL_Z1 = REG_ZERO_COEF_1;
	localparam logic [CIDX_W-1:0] SEL_Z2 = REG_ZERO_COEF_2;
	localparam logic [CIDX_W-1:0] SEL_P1 = REG_POLE_COEF_1;
	localparam logic [CIDX_W-1:0] SEL_P2 = REG_POLE_COEF_2;

	// Multiplier operand select codes
	localparam logic [1:0] OPD_D0 = 2'd0;
	localparam logic [1:0] OPD_D1 = 2'd1;
	localparam logic [1:0] OPD_D2 = 2'd2;

	// Accumulator operations
	localparam logic [2:0] ACC_HOLD    = 3'd0;
	localparam logic [2:0] ACC_LOAD_IN = 3'd1;
	localparam logic [2:0] ACC_SUB     = 3'd2;
	localparam logic [2:0] ACC_ADD     = 3'd3;
	localparam logic [2:0] ACC_LOAD_P  = 3'd4;

	// Branch conditions: go to the target when true, else stay on the step
	localparam logic [1:0] CND_ALWAYS = 2'd0;
	localparam logic [1:0] CND_IN     = 2'd1;
	localparam logic [1:0] CND_OUT    = 2'd2;

	// Program steps
	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] ST_IDLE  = 3'd0;
	localparam logic [STEP_W-1:0] ST_FB2   = 3'd1;
	localparam logic [STEP_W-1:0] ST_FBEND = 3'd2;
	localparam logic [STEP_W-1:0] ST_D0    = 3'd3;
	localparam logic [STEP_W-1:0] ST_FF1   = 3'd4;
	localparam logic [STEP_W-1:0] ST_FF2   = 3'd5;
	localparam logic [STEP_W-1:0] ST_OUT   = 3'd6;

	// Saturation limits at accumulator width
	localparam logic signed [ACC_W-1:0] D_MAX = (2 ** (DLY_W - 1)) - 1;
	localparam logic signed [ACC_W-1:0] D_MIN = -(2 ** (DLY_W - 1));
	localparam logic signed [ACC_W-1:0] S_MAX = (2 ** (SMP_W - 1)) - 1;
	localparam logic signed [ACC_W-1:0] S_MIN = -(2 ** (SMP_W - 1));

	// One control word
	typedef struct packed {
		logic              take_in;
		logic [CIDX_W-1:0] coef_sel;
		logic [1:0]        opnd_sel;
		logic [2:0]        acc_op;
		logic              cap_d0;
		logic              wr_out;
		logic [1:0]        cond;
		logic [STEP_W-1:0] target;
	} ctrl_t;

	// Branch status seen by the sequencer
	typedef struct packed {
		logic in_avail;
		logic out_free;
	} seq_stat_t;

	// Microcode ROM
	function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
		ctrl_t w;
		w = '0;
		unique case (step)
			ST_IDLE: begin
				w.take_in  = 1'b1;
				w.acc_op   = ACC_LOAD_IN;
				w.coef_sel = SEL_P1;
				w.opnd_sel = OPD_D1;
				w.cond     = CND_IN;
				w.target   = ST_FB2;
			end
			ST_FB2: begin
				w.acc_op   = ACC_SUB;
				w.coef_sel = SEL_P2;
				w.opnd_sel = OPD_D2;
				w.cond     = CND_ALWAYS;
				w.target   = ST_FBEND;
			end
			ST_FBEND: begin
				w.acc_op   = ACC_SUB;
				w.coef_sel = SEL_Z1;
				w.opnd_sel = OPD_D1;
				w.cond     = CND_ALWAYS;
				w.target   = ST_D0;
			end
			ST_D0: begin
				w.cap_d0   = 1'b1;
				w.acc_op   = ACC_LOAD_P;
				w.coef_sel = SEL_Z2;
				w.opnd_sel = OPD_D2;
				w.cond     = CND_ALWAYS;
				w.target   = ST_FF1;
			end
			ST_FF1: begin
				w.acc_op   = ACC_ADD;
				w.coef_sel = SEL_Z0;
				w.opnd_sel = OPD_D0;
				w.cond     = CND_ALWAYS;
				w.target   = ST_FF2;
			end
			ST_FF2: begin
				w.acc_op   = ACC_ADD;
				w.cond     = CND_ALWAYS;
				w.target   = ST_OUT;
			end
			ST_OUT: begin
				w.wr_out   = 1'b1;
				w.cond     = CND_OUT;
				w.target   = ST_IDLE;
			end
			default: begin
				w.cond     = CND_ALWAYS;
				w.target   = ST_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

FILE: rtl/biq_seq.sv
// Microcode sequencer: step counter, program ROM and conditional branch.
module biq_seq
	import biq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  seq_stat_t stat,
	output ctrl_t     ctrl
);

	logic [STEP_W-1:0] step_q;
	logic              go;

	// Fetch the control word of the current step
	assign ctrl = ucode(step_q);

	// Evaluate the branch condition
	always_comb begin
		unique case (ctrl.cond)
			CND_ALWAYS: go = 1'b1;
			CND_IN:     go = stat.in_avail;
			CND_OUT:    go = stat.out_free;
			default:    go = 1'b1;
		endcase
	end

	// Advance to the target or hold on the step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else if (go) begin
			step_q <= ctrl.target;
		end
	end

endmodule

FILE: rtl/biq_datapath.sv
// Datapath: coefficient registers, shared multiplier, accumulator, delay line.
module biq_datapath
	import biq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  ctrl_t                    ctrl,
	input  logic                     upd,
	input  logic                     cfg_we,
	input  logic [CIDX_W-1:0]        cfg_idx,
	input  logic signed [COEF_W-1:0] cfg_val,
	input  logic signed [SMP_W-1:0]  smp_in,
	output logic signed [SMP_W-1:0]  smp_out
);

	logic signed [COEF_W-1:0] coef_q [NUM_COEF];
	logic signed [DLY_W-1:0]  d0_q;
	logic signed [DLY_W-1:0]  d1_q;
	logic signed [DLY_W-1:0]  d2_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;

	logic signed [COEF_W-1:0] coef_mux;
	logic signed [DLY_W-1:0]  opnd_mux;
	logic signed [PROD_W-1:0] prod_sh;
	logic signed [ACC_W-1:0]  term;
	logic signed [DLY_W-1:0]  d0_sat;

	// Write coefficient registers, drop out-of-range indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEF; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cfg_we && (cfg_idx < CIDX_W'(NUM_COEF))) begin
			coef_q[cfg_idx] <= cfg_val;
		end
	end

	// Select multiplier operands
	always_comb begin
		coef_mux = (ctrl.coef_sel < CIDX_W'(NUM_COEF)) ? coef_q[ctrl.coef_sel] : '0;
		unique case (ctrl.opnd_sel)
			OPD_D0:  opnd_mux = d0_q;
			OPD_D1:  opnd_mux = d1_q;
			OPD_D2:  opnd_mux = d2_q;
			default: opnd_mux = '0;
		endcase
	end

	// Register the product
	always_ff @(posedge clk) begin
		prod_q <= coef_mux * opnd_mux;
	end

	// Drop the fraction bits with an arithmetic shift
	assign prod_sh = prod_q >>> FRAC_W;
	assign term    = ACC_W'(prod_sh[TERM_W-1:0]) | {{(ACC_W - TERM_W){prod_sh[TERM_W-1]}},
		{TERM_W{1'b0}}};

	// Accumulate
	always_ff @(posedge clk) begin
		unique case (ctrl.acc_op)
			ACC_HOLD:    acc_q <= acc_q;
			ACC_LOAD_IN: acc_q <= ACC_W'(smp_in);
			ACC_SUB:     acc_q <= acc_q - term;
			ACC_ADD:     acc_q <= acc_q + term;
			ACC_LOAD_P:  acc_q <= term;
			default:     acc_q <= acc_q;
		endcase
	end

	// Saturate the new delay value
	always_comb begin
		if (acc_q > D_MAX) begin
			d0_sat = DLY_W'(D_MAX);
		end else if (acc_q < D_MIN) begin
			d0_sat = DLY_W'(D_MIN);
		end else begin
			d0_sat = DLY_W'(acc_q);
		end
	end

	// Hold the current delay value for the feedforward pass
	always_ff @(posedge clk) begin
		if (ctrl.cap_d0) begin
			d0_q <= d0_sat;
		end
	end

	// Shift the delay line once the result is stored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_q <= '0;
			d2_q <= '0;
		end else if (upd) begin
			d2_q <= d1_q;
			d1_q <= d0_q;
		end
	end

	// Saturate the output sample
	always_comb begin
		if (acc_q > S_MAX) begin
			smp_out = SMP_W'(S_MAX);
		end else if (acc_q < S_MIN) begin
			smp_out = SMP_W'(S_MIN);
		end else begin
			smp_out = SMP_W'(acc_q);
		end
	end

endmodule

FILE: rtl/biquad_iir_filter.sv
// Top level of the direct form II biquad filter.
//
// Input samples arrive on the s_axis channel, one signed 16-bit sample per
// transfer; each gives exactly one filtered sample on the m_axis channel.
// The five Q2.14 coefficients are written on the cfg channel (index 0..2
// zero coefficients 0..2, index 3..4 pole coefficients 1..2); cfg_ready is
// always high and writes to other indexes are dropped. Write coefficients
// only while no sample is in flight.
// A shared 16x24 multiplier runs the program of seven steps: one step takes
// the sample, five steps multiply and accumulate, one step stores the
// result. A new sample is taken only once the program has stored the
// last result and returned to its idle step.
// The result sits in an output register, so the next sample is processed
// while it waits; if the receiver still stalls when the next result is
// done, the sequencer holds on its store step and s_axis_tready stays low.
// Reset clears the coefficients, the delay line and the output valid.
module biquad_iir_filter
	import biq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [15:0]       s_axis_tdata,   // [15:0] sample_in
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [15:0]       m_axis_tdata,   // [15:0] sample_out
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [15:0]       cfg_data
);

	ctrl_t                   ctrl;
	seq_stat_t               stat;
	logic                    out_free;
	logic                    upd;
	logic signed [SMP_W-1:0] smp_out;
	logic                    out_valid_q;
	logic [SMP_W-1:0]        out_data_q;

	// Output register is free when empty or draining this cycle
	assign out_free      = !out_valid_q || m_axis_tready;
	assign upd           = ctrl.wr_out && out_free;
	assign stat.in_avail = s_axis_tvalid;
	assign stat.out_free = out_free;

	assign s_axis_tready = ctrl.take_in;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	biq_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	biq_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.upd     (upd),
		.cfg_we  (cfg_valid),
		.cfg_idx (cfg_index),
		.cfg_val (cfg_data),
		.smp_in  (s_axis_tdata),
		.smp_out (smp_out)
	);

	// Track output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the result
	always_ff @(posedge clk) begin
		if (upd) begin
			out_data_q <= smp_out;
		end
	end

	// A taken sample starts the program, so input closes next cycle
	a_take_closes: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input still open after a sample transfer");

	// Storing a result presents it and returns to the idle step
	a_store_shows: assert property (@(posedge clk) disable iff (!arst_n)
		upd |=> m_axis_tvalid && s_axis_tready)
		else $error("stored result not presented or sequencer not idle");

	// The sequencer never stores over a result the receiver has not taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.wr_out && m_axis_tvalid && !m_axis_tready |=> ctrl.wr_out)
		else $error("result store left the stall step while output was blocked");

endmodule

FILE: bench/biquad_response_checker.sv
`timescale 1ns / 100ps
// Checker that predicts the biquad output stream and compares it with the block.
module biquad_response_checker
	import biq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	input  logic              s_axis_tready,
	input  logic [15:0]       s_axis_tdata,   // [15:0] sample_in
	input  logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	input  logic [15:0]       m_axis_tdata,   // [15:0] sample_out
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [15:0]       cfg_data,
	output int unsigned       fail_count,
	output int unsigned       pending,
	output int unsigned       checked
);

	logic signed [COEF_W-1:0] coef_q [NUM_COEF];
	logic signed [DLY_W-1:0]  dly_first;
	logic signed [DLY_W-1:0]  dly_second;
	logic signed [SMP_W-1:0]  expected_samples [$];
	int unsigned              mismatches;
	int unsigned              matched;

	// Q2.14 product, floored by the arithmetic shift
	function automatic longint frac_mul(input logic signed [COEF_W-1:0] c, input longint v);
		return (longint'(c) * v) >>> FRAC_W;
	endfunction

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Run one sample through the filter and advance the delay line
	function automatic logic signed [SMP_W-1:0] filter_step(input logic signed [SMP_W-1:0] x);
		longint d0;
		longint y;
		d0 = longint'(x) - frac_mul(coef_q[REG_POLE_COEF_1], dly_first)
		     - frac_mul(coef_q[REG_POLE_COEF_2], dly_second);
		d0 = clip(d0, D_MIN, D_MAX);
		y = frac_mul(coef_q[REG_ZERO_COEF_0], d0)
		    + frac_mul(coef_q[REG_ZERO_COEF_1], dly_first)
		    + frac_mul(coef_q[REG_ZERO_COEF_2], dly_second);
		y = clip(y, S_MIN, S_MAX);
		dly_second = dly_first;
		dly_first  = d0[DLY_W-1:0];
		return y[SMP_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic signed [SMP_W-1:0] want;
		if (!arst_n) begin
			foreach (coef_q[i])
				coef_q[i] = '0;
			dly_first  = '0;
			dly_second = '0;
			expected_samples.delete();
			mismatches = 0;
			matched    = 0;
		end else begin
			// compare each output transfer with the oldest prediction
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_samples.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected sample_out %0d, expected none",
						$time, $signed(m_axis_tdata));
				end else begin
					want = expected_samples.pop_front();
					if (m_axis_tdata !== want) begin
						mismatches++;
						$display("%0t: sample_out mismatch: expected %0d, actual %0d",
							$time, want, $signed(m_axis_tdata));
					end else begin
						matched++;
					end
				end
			end
			// track coefficient writes; unused indexes are dropped
			if (cfg_valid && cfg_ready && cfg_index < NUM_COEF)
				coef_q[cfg_index] = cfg_data;
			// predict the result of each input transfer
			if (s_axis_tvalid && s_axis_tready)
				expected_samples.push_back(filter_step(s_axis_tdata));
		end
		fail_count <= mismatches;
		pending    <= expected_samples.size();
		checked    <= matched;
	end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the biquad filter: clock, reset, stimulus and verdict.
module tb_top
	import biq_pkg::*;
();

	localparam int HALF_PERIOD   = 4;
	localparam int RESET_CYCLES  = 4;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES  = 20;
	localparam int LONG_HOLD     = 400;
	localparam int STUCK_LIMIT   = 2000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 105;
	localparam int HOLD_PHASE    = 2;
	localparam int Q_ONE         = 1 << FRAC_W;
	localparam int STABLE_P2_MAX = 14745;  // 0.9 in Q2.14

	localparam logic [15:0] COEF_ONE    = 16'h4000;
	localparam logic [15:0] COEF_MAX    = 16'h7FFF;
	localparam logic [15:0] COEF_MIN    = 16'h8000;
	localparam logic [15:0] SMP_HI      = 16'h7FFF;
	localparam logic [15:0] SMP_LO      = 16'h8000;
	localparam logic [15:0] WAVE_TOP    = 16'h6000;
	localparam logic [15:0] WAVE_BOTTOM = 16'hA000;

	typedef enum logic [1:0] {WAVE_NOISE, WAVE_IMPULSE, WAVE_SQUARE} wave_e;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [15:0]       s_axis_tdata;   // [15:0] sample_in
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [15:0]       m_axis_tdata;   // [15:0] sample_out
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CIDX_W-1:0] cfg_index;
	logic [15:0]       cfg_data;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned checked;
	int unsigned sender_gap_pct = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned holds_asked    = 0;
	int unsigned holds_done     = 0;
	int unsigned samples_sent   = 0;
	int unsigned reg_writes     = 0;
	int unsigned settings_used  = 0;

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	biquad_iir_filter u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	biquad_response_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending),
		.checked       (checked)
	);

	// Offer one sample, maybe after an idle burst, and wait for its transfer
	task automatic send_sample(input logic [15:0] value);
		if ($urandom_range(1, 100) <= sender_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		do @(posedge clk); while (!s_axis_tready);
		samples_sent++;
	endtask

	task automatic write_reg(input logic [CIDX_W-1:0] index, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		reg_writes++;
	endtask

	// Load all five coefficients, optionally after a write to an unused index
	task automatic load_coefs(input bit with_stray,
			input logic [15:0] z0, z1, z2, p1, p2);
		if (with_stray)
			write_reg(CIDX_W'($urandom_range(NUM_COEF, (1 << CIDX_W) - 1)),
				16'($urandom()));
		write_reg(REG_ZERO_COEF_0, z0);
		write_reg(REG_ZERO_COEF_1, z1);
		write_reg(REG_ZERO_COEF_2, z2);
		write_reg(REG_POLE_COEF_1, p1);
		write_reg(REG_POLE_COEF_2, p2);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Drop the channels and hold until every prediction has been compared
	task automatic wait_quiet();
		s_axis_tvalid <= 1'b0;
		cfg_valid     <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_coef();
		case ($urandom_range(0, 5))
			0: return COEF_MAX;
			1: return COEF_MIN;
			2: return '0;
			3: return COEF_ONE;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [15:0] pick_sample(input wave_e wave, input int unsigned n);
		case (wave)
			WAVE_IMPULSE:
				if (n % 16 != 0)
					return '0;
				else
					return ($urandom_range(0, 1) != 0) ? SMP_HI : SMP_LO;
			WAVE_SQUARE:
				return ((n / 8) % 2 == 0) ? WAVE_TOP : WAVE_BOTTOM;
			default:
				case ($urandom_range(0, 7))
					0: return SMP_HI;
					1: return SMP_LO;
					2: return 16'($urandom_range(0, 255));
					3: return ~16'($urandom_range(0, 255));
					default: return 16'($urandom());
				endcase
		endcase
	endfunction

	function automatic int unsigned burst_odds();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 5;
			default: return 25;
		endcase
	endfunction

	initial begin : stimulus
		logic [15:0] follow_set [7];
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		cfg_valid     <= 1'b0;
		cfg_index     <= '0;
		cfg_data      <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// coefficients at reset: output stays at zero
		send_sample(SMP_HI);
		send_sample(SMP_LO);
		wait_quiet();

		// unity feedforward, no feedback: output follows the input
		follow_set = '{16'h0000, 16'h0001, 16'hFFFF, SMP_HI, SMP_LO, 16'h5555, 16'hAAAA};
		load_coefs(1'b1, COEF_ONE, '0, '0, '0, '0);
		foreach (follow_set[i])
			send_sample(follow_set[i]);
		wait_quiet();

		// extreme gains and feedback: drive delay and output into saturation
		load_coefs(1'b1, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN);
		repeat (8) send_sample(SMP_HI);
		repeat (4) send_sample(SMP_LO);
		wait_quiet();

		// random settings, mostly stable filters fed with shaped signals
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			bit    stable;
			int    p1;
			int    p2;
			int    span;
			wave_e wave;
			stable = (ph != 1) && ($urandom_range(0, 3) != 0);
			if (stable) begin
				p2   = $urandom_range(0, STABLE_P2_MAX);
				span = Q_ONE - 1 + p2;
				p1   = int'($urandom_range(0, 2 * span)) - span;
				load_coefs(ph % 2 == 0,
					16'(int'($urandom_range(0, Q_ONE)) - Q_ONE / 2),
					16'(int'($urandom_range(0, Q_ONE)) - Q_ONE / 2),
					16'(int'($urandom_range(0, Q_ONE)) - Q_ONE / 2),
					16'(p1), 16'(p2));
			end else begin
				load_coefs(ph % 2 == 0, pick_coef(), pick_coef(), pick_coef(),
					pick_coef(), pick_coef());
			end
			wave = wave_e'($urandom_range(0, 2));
			if (ph == RANDOM_PHASES - 1) begin
				sender_gap_pct = 0;
				sink_stall_pct <= 0;
			end else if (ph == HOLD_PHASE) begin
				// keep offering while the receiver holds off, so the input stalls
				sender_gap_pct = 0;
				holds_asked <= holds_asked + 1;
			end else begin
				sender_gap_pct = burst_odds();
				sink_stall_pct <= burst_odds();
			end
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_sample(pick_sample(wave, n));
			wait_quiet();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d samples and %0d register writes over %0d coefficient settings.",
			samples_sent, reg_writes, settings_used);
		$display("Checked %0d filtered samples, %0d failures.", checked, fail_count);
		if (fail_count == 0)
			$display("** biquad_iir_filter: PASSED **");
		else
			$display("** biquad_iir_filter: FAILED **");
		$finish;
	end

	// Receiver: ready between random stall bursts, with one long hold-off
	initial begin : sink
		m_axis_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (holds_done != holds_asked) begin
				holds_done++;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if ($urandom_range(1, 100) <= sink_stall_pct) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Watchdog: end the run when no transfer happens for too long
	initial begin : watchdog
		int unsigned stuck;
		stuck = 0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		while (stuck < STUCK_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready))
				stuck = 0;
			else
				stuck++;
		end
		$display("%0t: no transfer for %0d cycles, %0d results outstanding",
			$time, STUCK_LIMIT, pending);
		$display("** biquad_iir_filter: FAILED **");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/biq_pkg.sv
rtl/biq_seq.sv
rtl/biq_datapath.sv
rtl/biquad_iir_filter.sv
bench/biquad_response_checker.sv
bench/tb_top.sv
